/* rtl/core/e2m1dp_pkg.sv */
// Shared types, widths and the E2M1 magnitude table for the E2M1 by int4 dot product.
`timescale 1ns / 1ps

package e2m1dp_pkg;

    localparam int FIELD_BITS   = 32;   // width of each packed input field
    localparam int NIB_BITS     = 4;    // one lane's nibble
    localparam int Q_BITS       = 5;    // decoded weight, twice its value, -12..12
    localparam int LO_PROD_BITS = 8;    // activation times low plane, -48..48
    localparam int HI_PROD_BITS = 5;    // activation times high plane, -8..8
    localparam int DOT_BITS     = 32;   // result width

    // Decoded weights at or beyond this magnitude carry into the high plane.
    localparam logic signed [Q_BITS-1:0] Q_SPLIT = 5'sd8;

    typedef logic [NIB_BITS-1:0] nibble_t;

    // Control that travels with a beat through the lane stage.
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctrl_t;

    // Twice the E2M1 magnitude for a 3-bit code.
    function automatic logic [NIB_BITS-1:0] mag_twice(input logic [2:0] code);
        logic [NIB_BITS-1:0] mag;
        unique case (code)
            3'd0:    mag = 4'd0;
            3'd1:    mag = 4'd1;
            3'd2:    mag = 4'd2;
            3'd3:    mag = 4'd3;
            3'd4:    mag = 4'd4;
            3'd5:    mag = 4'd6;
            3'd6:    mag = 4'd8;
            3'd7:    mag = 4'd12;
            default: mag = 4'd0;
        endcase
        return mag;
    endfunction

endpackage

/* rtl/core/e2m1dp_lane.sv */
// One lane: decode an E2M1 nibble, split it into two planes, register both products.
`timescale 1ns / 1ps

module e2m1dp_lane (
    input  logic                                    clk,
    input  logic                                    load,
    input  e2m1dp_pkg::nibble_t                     act_nibble,
    input  e2m1dp_pkg::nibble_t                     weight_nibble,
    output logic signed [e2m1dp_pkg::LO_PROD_BITS-1:0] lo_prod,
    output logic signed [e2m1dp_pkg::HI_PROD_BITS-1:0] hi_prod
);
    import e2m1dp_pkg::*;

    logic        [NIB_BITS-1:0]     mag;
    logic signed [Q_BITS-1:0]       q;
    logic signed [NIB_BITS-1:0]     w_lo;
    logic signed [LO_PROD_BITS-1:0] act_ext;
    logic signed [LO_PROD_BITS-1:0] w_lo_ext;
    logic signed [HI_PROD_BITS-1:0] act_hi_ext;
    logic signed [LO_PROD_BITS-1:0] lo_prod_next;
    logic signed [HI_PROD_BITS-1:0] hi_prod_next;
    logic signed [LO_PROD_BITS-1:0] lo_prod_reg;
    logic signed [HI_PROD_BITS-1:0] hi_prod_reg;

    always_comb
    begin
        mag        = mag_twice(weight_nibble[2:0]);
        q          = weight_nibble[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        act_ext    = LO_PROD_BITS'($signed(act_nibble));
        act_hi_ext = HI_PROD_BITS'($signed(act_nibble));
        priority if (q >= Q_SPLIT)
        begin
            w_lo         = NIB_BITS'(q - Q_SPLIT);
            hi_prod_next = act_hi_ext;
        end
        else if (q <= -Q_SPLIT)
        begin
            w_lo         = NIB_BITS'(q + Q_SPLIT);
            hi_prod_next = -act_hi_ext;
        end
        else
        begin
            w_lo         = NIB_BITS'(q);
            hi_prod_next = '0;
        end
        w_lo_ext     = LO_PROD_BITS'(w_lo);
        lo_prod_next = act_ext * w_lo_ext;
    end

    // Hold the products until the next accepted beat.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

    assign lo_prod = lo_prod_reg;
    assign hi_prod = hi_prod_reg;

endmodule

/* rtl/core/e2m1dp_merge.sv */
// Lane merge: adder trees over the lane products and the two plane accumulators.
`timescale 1ns / 1ps

module e2m1dp_merge #(
    parameter int LANES    = 8,
    parameter int SUM_BITS = 40
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  e2m1dp_pkg::beat_ctrl_t                     lane_ctrl,
    input  logic signed [e2m1dp_pkg::LO_PROD_BITS-1:0] lo_prods [LANES],
    input  logic signed [e2m1dp_pkg::HI_PROD_BITS-1:0] hi_prods [LANES],
    input  logic                                       out_ready,
    output logic                                       advance,
    output logic                                       fin_valid,
    output logic [SUM_BITS-1:0]                        fin_lo,
    output logic [SUM_BITS-1:0]                        fin_hi
);
    import e2m1dp_pkg::*;

    localparam int PAD     = 1 << $clog2(LANES);
    localparam int LO_BITS = LO_PROD_BITS + $clog2(LANES);
    localparam int HI_BITS = HI_PROD_BITS + $clog2(LANES);

    logic signed [LO_BITS-1:0] tree_lo [1:2*PAD-1];
    logic signed [HI_BITS-1:0] tree_hi [1:2*PAD-1];
    logic [SUM_BITS-1:0]       sum_lo;
    logic [SUM_BITS-1:0]       sum_hi;
    logic [SUM_BITS-1:0]       acc_lo_reg;
    logic [SUM_BITS-1:0]       acc_hi_reg;
    logic [SUM_BITS-1:0]       fin_lo_reg;
    logic [SUM_BITS-1:0]       fin_hi_reg;
    logic                      fin_valid_reg;
    logic                      fin_valid_next;
    logic                      fin_ready;

    // Pairwise tree: leaves at PAD.., each node adds its two children.
    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            if (i < LANES)
            begin
                tree_lo[PAD+i] = LO_BITS'(lo_prods[i]);
                tree_hi[PAD+i] = HI_BITS'(hi_prods[i]);
            end
            else
            begin
                tree_lo[PAD+i] = '0;
                tree_hi[PAD+i] = '0;
            end
        end
        for (int j = PAD - 1; j >= 1; j--)
        begin
            tree_lo[j] = tree_lo[2*j] + tree_lo[2*j+1];
            tree_hi[j] = tree_hi[2*j] + tree_hi[2*j+1];
        end
    end

    assign sum_lo = acc_lo_reg + SUM_BITS'(tree_lo[1]);
    assign sum_hi = acc_hi_reg + SUM_BITS'(tree_hi[1]);

    // A last beat needs room in the final-sum register; others always advance.
    assign fin_ready = !fin_valid_reg || out_ready;
    assign advance   = lane_ctrl.valid && (!lane_ctrl.last || fin_ready);

    always_comb
    begin
        fin_valid_next = fin_valid_reg && !out_ready;
        if (advance && lane_ctrl.last)
        begin
            fin_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_lo_reg    <= '0;
            acc_hi_reg    <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (advance)
            begin
                if (lane_ctrl.last)
                begin
                    acc_lo_reg <= '0;
                    acc_hi_reg <= '0;
                end
                else
                begin
                    acc_lo_reg <= sum_lo;
                    acc_hi_reg <= sum_hi;
                end
            end
        end
    end

    // Capture the closing sums of a dot product.
    always_ff @(posedge clk)
    begin
        if (advance && lane_ctrl.last)
        begin
            fin_lo_reg <= sum_lo;
            fin_hi_reg <= sum_hi;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_lo    = fin_lo_reg;
    assign fin_hi    = fin_hi_reg;

endmodule

/* rtl/core/e2m1_by_int4_dot_product.sv */
// Top level of the E2M1-weight by signed 4-bit activation dot product.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  group    | group_valid / group_stall    | activations, weight_codes, last
//  result   | result_valid / result_stall  | dot_value, overflow
//
// One group beat is taken per cycle while group_stall is low. The lane registers,
// the final-sum register and the output register form a three-register pipeline.
// The lane registers load at the edge that takes the beat; the closing sums of a
// dot product then pass through the final-sum register into the output register.
// Reset clears the accumulators and every valid flag; payload registers are not reset.
// A stalled result blocks a later last beat at the merge stage; beats that are
// not last keep flowing into the accumulators meanwhile.
`timescale 1ns / 1ps

module e2m1_by_int4_dot_product #(
    parameter int LANES    = 8,
    parameter int SUM_BITS = 40
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   group_valid,
    output logic                                   group_stall,
    input  logic [e2m1dp_pkg::FIELD_BITS-1:0]      activations,
    input  logic [e2m1dp_pkg::FIELD_BITS-1:0]      weight_codes,
    input  logic                                   last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [e2m1dp_pkg::DOT_BITS-1:0] dot_value,
    output logic                                   overflow
);
    import e2m1dp_pkg::*;

    localparam int TOTAL_BITS = SUM_BITS + 4;

    beat_ctrl_t                      lane_ctrl_reg;
    logic                            lane_ready;
    logic                            group_fire;
    logic                            advance;
    logic                            out_ready;
    logic                            fin_valid;
    logic [SUM_BITS-1:0]             fin_lo;
    logic [SUM_BITS-1:0]             fin_hi;
    logic signed [LO_PROD_BITS-1:0]  lo_prods [LANES];
    logic signed [HI_PROD_BITS-1:0]  hi_prods [LANES];
    logic signed [TOTAL_BITS-1:0]    total;
    logic                            overflow_next;
    logic                            result_valid_reg;
    logic signed [DOT_BITS-1:0]      dot_value_reg;
    logic                            overflow_reg;

    // The lane registers free up when empty or when the merge stage takes them.
    assign lane_ready  = !lane_ctrl_reg.valid || advance;
    assign group_stall = !lane_ready;
    assign group_fire  = group_valid && lane_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_ctrl_reg <= '0;
        end
        else if (lane_ready)
        begin
            lane_ctrl_reg.valid <= group_valid;
            lane_ctrl_reg.last  <= last;
        end
    end

    // Lanes past the packed fields see zero nibbles and add nothing.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        nibble_t act_nib;
        nibble_t wgt_nib;
        if (g * NIB_BITS < FIELD_BITS)
        begin : g_field
            assign act_nib = activations[g*NIB_BITS +: NIB_BITS];
            assign wgt_nib = weight_codes[g*NIB_BITS +: NIB_BITS];
        end
        else
        begin : g_pad
            assign act_nib = '0;
            assign wgt_nib = '0;
        end
        e2m1dp_lane u_lane (
            .clk           (clk),
            .load          (group_fire),
            .act_nibble    (act_nib),
            .weight_nibble (wgt_nib),
            .lo_prod       (lo_prods[g]),
            .hi_prod       (hi_prods[g])
        );
    end

    e2m1dp_merge #(
        .LANES    (LANES),
        .SUM_BITS (SUM_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctrl (lane_ctrl_reg),
        .lo_prods  (lo_prods),
        .hi_prods  (hi_prods),
        .out_ready (out_ready),
        .advance   (advance),
        .fin_valid (fin_valid),
        .fin_lo    (fin_lo),
        .fin_hi    (fin_hi)
    );

    // Combine the planes: low + 8*high, exact in TOTAL_BITS, then wrap to 32 bits.
    // Overflow when the bits above bit 31 are not all copies of the sign.
    assign total = TOTAL_BITS'($signed(fin_lo)) + (TOTAL_BITS'($signed(fin_hi)) <<< 3);
    assign overflow_next = !((&total[TOTAL_BITS-1:DOT_BITS-1]) ||
                             !(|total[TOTAL_BITS-1:DOT_BITS-1]));

    // Output register: load whenever empty or the current beat is taken.
    assign out_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            result_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && fin_valid)
        begin
            dot_value_reg <= total[DOT_BITS-1:0];
            overflow_reg  <= overflow_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign dot_value    = dot_value_reg;
    assign overflow     = overflow_reg;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the E2M1 by int4 dot product: directed table, then random groups.
`timescale 1ns / 1ps

module testbench;

    localparam int LANE_COUNT = e2m1dp_pkg::FIELD_BITS / e2m1dp_pkg::NIB_BITS;
    localparam int SUM_WIDTH  = 40;
    localparam int FB         = e2m1dp_pkg::FIELD_BITS;
    localparam int DB         = e2m1dp_pkg::DOT_BITS;

    // Decoded weights at or beyond this magnitude spill into the high plane.
    localparam int PLANE_SPLIT = 8;
    localparam longint DOT_MAX = 64'sd2147483647;
    localparam longint DOT_MIN = -64'sd2147483648;

    // Twice the E2M1 magnitude, indexed by the 3-bit code.
    localparam int E2M1_TWICE [8] = '{0, 1, 2, 3, 4, 6, 8, 12};

    localparam int RANDOM_GROUPS = 750;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic signed [DB-1:0] dot;
        logic                 ovf;
    } dot_result_t;

    // One row of the directed table: payload, plus a typed-in result where known.
    typedef struct packed {
        logic [FB-1:0]        acts;
        logic [FB-1:0]        wts;
        logic                 lst;
        logic                 known;
        logic signed [DB-1:0] dot;
        logic                 ovf;
    } group_row_t;

    localparam int N_ROWS = 18;

    // Typed results follow a last beat (or reset), so the sums start from zero.
    localparam group_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{32'h00000000, 32'h00000000, 1'b1, 1'b1,    0, 1'b0},
        '{32'h77777777, 32'h77777777, 1'b1, 1'b1,  672, 1'b0},
        '{32'h88888888, 32'hFFFFFFFF, 1'b1, 1'b1,  768, 1'b0},
        '{32'h88888888, 32'h77777777, 1'b1, 1'b1, -768, 1'b0},
        '{32'h77777777, 32'hFFFFFFFF, 1'b1, 1'b1, -672, 1'b0},
        '{32'h11111111, 32'h76543210, 1'b1, 1'b1,   36, 1'b0},
        '{32'h11111111, 32'hFEDCBA98, 1'b1, 1'b1,  -36, 1'b0},
        '{32'hFFFFFFFF, 32'h76543210, 1'b1, 1'b1,  -36, 1'b0},
        '{32'h77777777, 32'h88888888, 1'b1, 1'b1,    0, 1'b0},
        '{32'h00000007, 32'h00000006, 1'b1, 1'b1,   56, 1'b0},
        '{32'h00000007, 32'h0000000E, 1'b1, 1'b1,  -56, 1'b0},
        '{32'h80000000, 32'h70000000, 1'b1, 1'b1,  -96, 1'b0},
        '{32'h12345678, 32'h9ABCDEF0, 1'b0, 1'b0,    0, 1'b0},
        '{32'h8F8F8F8F, 32'h7E7E7E7E, 1'b0, 1'b0,    0, 1'b0},
        '{32'hF0F0F0F0, 32'hC3A5C3A5, 1'b1, 1'b0,    0, 1'b0},
        '{32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1, 1'b0,    0, 1'b0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0,    0, 1'b0},
        '{32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0,    0, 1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 group_valid = 1'b0;
    logic                 group_stall;
    logic [FB-1:0]        activations = '0;
    logic [FB-1:0]        weight_codes = '0;
    logic                 last = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic signed [DB-1:0] dot_value;
    logic                 overflow;

    // Predictor state: the two plane accumulators, wrapped at SUM_WIDTH bits.
    logic signed [SUM_WIDTH-1:0] low_plane_acc = '0;
    logic signed [SUM_WIDTH-1:0] high_plane_acc = '0;

    dot_result_t pending_dots [$];

    int  mismatches = 0;
    bit  calm = 1'b0;       // no idling on either side while set
    int  holds_asked = 0;   // bumped by the sender to request a long result hold-off

    e2m1_by_int4_dot_product #(
        .LANES    (LANE_COUNT),
        .SUM_BITS (SUM_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .group_valid  (group_valid),
        .group_stall  (group_stall),
        .activations  (activations),
        .weight_codes (weight_codes),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .dot_value    (dot_value),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one group into the plane sums; on a last group, form the result and clear.
    function automatic bit fold_group(input logic [FB-1:0] acts, input logic [FB-1:0] wts,
                                      input logic lst, output dot_result_t res);
        logic [3:0] act_nib;
        logic [3:0] wt_nib;
        int         act;
        int         q;
        int         w_lo;
        int         w_hi;
        longint     total;
        res = '0;
        for (int lane = 0; lane < LANE_COUNT; lane++)
        begin
            act_nib = acts[4*lane +: 4];
            wt_nib  = wts[4*lane +: 4];
            act     = $signed(act_nib);
            q       = E2M1_TWICE[wt_nib[2:0]];
            if (wt_nib[3])
                q = -q;
            // Split q into low + 8*high with both planes in s4 range.
            if (q >= PLANE_SPLIT)
            begin
                w_hi = 1;
                w_lo = q - PLANE_SPLIT;
            end
            else if (q <= -PLANE_SPLIT)
            begin
                w_hi = -1;
                w_lo = q + PLANE_SPLIT;
            end
            else
            begin
                w_hi = 0;
                w_lo = q;
            end
            low_plane_acc  = low_plane_acc + SUM_WIDTH'(act * w_lo);
            high_plane_acc = high_plane_acc + SUM_WIDTH'(act * w_hi);
        end
        if (!lst)
            return 1'b0;
        total   = longint'(low_plane_acc) + longint'(high_plane_acc) * 8;
        res.dot = total[DB-1:0];
        res.ovf = (total > DOT_MAX) || (total < DOT_MIN);
        low_plane_acc  = '0;
        high_plane_acc = '0;
        return 1'b1;
    endfunction

    // Drop valid for a random number of cycles, about 27 in a hundred overall.
    task automatic idle_sender();
        while (!calm && $urandom_range(99) < 27)
        begin
            group_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one beat, hold it until taken, then log what it should produce.
    task automatic offer_group(input logic [FB-1:0] acts, input logic [FB-1:0] wts,
                               input logic lst, input logic known, input dot_result_t typed);
        dot_result_t predicted;
        idle_sender();
        group_valid  <= 1'b1;
        activations  <= acts;
        weight_codes <= wts;
        last         <= lst;
        @(posedge clk);
        while (group_stall)
            @(posedge clk);
        if (fold_group(acts, wts, lst, predicted))
            pending_dots.push_back(known ? typed : predicted);
    endtask

    // Result side: check each beat taken, then pick the stall for the next cycle.
    initial
    begin
        dot_result_t want;
        int          hold_left;
        int          holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_dots.size() == 0)
                begin
                    $error("unexpected result beat: dot_value=%0d overflow=%0b",
                           dot_value, overflow);
                    mismatches++;
                end
                else
                begin
                    want = pending_dots.pop_front();
                    if (dot_value !== want.dot)
                    begin
                        $error("dot_value mismatch: expected %0d, actual %0d",
                               want.dot, dot_value);
                        mismatches++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow mismatch: expected %0b, actual %0b",
                               want.ovf, overflow);
                        mismatches++;
                    end
                end
            end
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    // Sender: reset, directed table, random groups, drain, verdict.
    initial
    begin
        dot_result_t none;
        logic [FB-1:0] acts;
        logic [FB-1:0] wts;
        logic          lst;
        int            mode;
        none = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            offer_group(DIRECTED_ROWS[r].acts, DIRECTED_ROWS[r].wts, DIRECTED_ROWS[r].lst,
                        DIRECTED_ROWS[r].known,
                        '{dot: DIRECTED_ROWS[r].dot, ovf: DIRECTED_ROWS[r].ovf});

        for (int k = 0; k < RANDOM_GROUPS; k++)
        begin
            // A stretch with no idling on either side.
            calm = (k >= 100) && (k < 220);

            // Stall the result side for a long stretch and keep pushing last beats,
            // so the pipeline backs up into the group channel.
            if (k == 300)
                holds_asked++;

            // Stop offering until every outstanding result has come back.
            if (k == 500)
            begin
                group_valid <= 1'b0;
                @(posedge clk);
                while (pending_dots.size() != 0)
                    @(posedge clk);
            end

            acts = $urandom;
            wts  = $urandom;
            mode = $urandom_range(9);
            if (mode == 0)
                acts = $urandom_range(1) ? {LANE_COUNT{4'h8}} : {LANE_COUNT{4'h7}};
            else if (mode == 1)
                wts = $urandom_range(1) ? {LANE_COUNT{4'h7}} : {LANE_COUNT{4'hF}};
            else if (mode == 2)
                acts = '0;

            if (k >= 300 && k < 340)
                lst = 1'b1;
            else if (k >= 600 && k < 650)
                lst = ($urandom_range(15) == 0);   // long accumulations
            else
                lst = ($urandom_range(3) == 0);

            // Close the final dot product so its result is checked.
            if (k == RANDOM_GROUPS - 1)
                lst = 1'b1;

            offer_group(acts, wts, lst, 1'b0, none);
        end

        calm = 1'b0;
        group_valid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* e2m1_by_int4_dot_product.f */
rtl/core/e2m1dp_pkg.sv
rtl/core/e2m1dp_lane.sv
rtl/core/e2m1dp_merge.sv
rtl/core/e2m1_by_int4_dot_product.sv
bench/testbench.sv
